>>> hw/rtl/n2a_pkg.sv
// Shared types, constants and helpers of the number-to-ASCII formatter.
package n2a_pkg;

	localparam int VALUE_BITS  = 64;
	localparam int MAX_CHARS   = 20;
	localparam int STORE_DEPTH = 20;
	localparam int QUEUE_DEPTH = 2;

	localparam int BIT_W      = $clog2(VALUE_BITS);
	localparam int DIG_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W      = $clog2(STORE_DEPTH + 1);
	localparam int LEN_W      = $clog2(STORE_DEPTH + 3);
	localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_LOWER_X = 8'h78;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;

	typedef enum logic [1:0] {
		OP_DEC    = 2'd0,
		OP_HEX_LO = 2'd1,
		OP_HEX_UP = 2'd2,
		OP_PTR    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		B_IDLE = 2'd0,
		B_CONV = 2'd1,
		B_SIZE = 2'd2,
		B_EMIT = 2'd3
	} back_state_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] mag;
		op_t                   op;
		logic                  neg;
	} job_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] base;
		base = upper ? CH_UPPER_A : CH_LOWER_A;
		if (d < 4'd10) begin
			return CH_ZERO + {4'b0, d};
		end
		return base + {4'b0, d} - 8'd10;
	endfunction

endpackage

>>> hw/rtl/n2a_front.sv
// Front stage: accept a transfer, fold the sign and register the classified job.
module n2a_front import n2a_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] value,
	input  logic [1:0]  operation,
	output logic        job_valid,
	input  logic        job_ready,
	output job_t        job
);

	logic                  valid_s1;
	job_t                  job_s1;
	job_t                  job_c;
	logic [VALUE_BITS-1:0] v;

	always_comb begin
		v          = value[VALUE_BITS-1:0];
		job_c.op   = op_t'(operation);
		job_c.neg  = (job_c.op == OP_DEC) && v[VALUE_BITS-1];
		job_c.mag  = job_c.neg ? VALUE_BITS'(~v + 1'b1) : v;
	end

	assign in_ready  = !valid_s1 || job_ready;
	assign job_valid = valid_s1;
	assign job       = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			job_s1 <= job_c;
		end
	end

endmodule

>>> hw/rtl/n2a_queue.sv
// Short job queue between the front stage and the conversion engine.
module n2a_queue import n2a_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_job,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_job
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

>>> hw/rtl/n2a_back.sv
// Back engine: bit-serial decimal conversion, digit sizing and character output.
module n2a_back import n2a_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_valid,
	output logic       job_ready,
	input  job_t       job,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] character,
	output logic       last
);

	back_state_t           state_q;
	back_state_t           state_d;
	logic [3:0]            digits_q [STORE_DEPTH];
	logic [3:0]            conv_c [STORE_DEPTH];
	logic [3:0]            hex_c [STORE_DEPTH];
	logic [3:0]            adj [STORE_DEPTH];
	logic [STORE_DEPTH*4-1:0] hpad;
	logic [VALUE_BITS-1:0] shift_q;
	logic [BIT_W-1:0]      bit_cnt_q;
	op_t                   op_q;
	logic                  neg_q;
	logic [CNT_W-1:0]      ndig_c;
	logic [LEN_W-1:0]      ndig_q;
	logic [1:0]            pre_q;
	logic [LEN_W-1:0]      len_c;
	logic [LEN_W-1:0]      len_q;
	logic [LEN_W-1:0]      pos_q;
	logic [LEN_W-1:0]      idx_c;
	logic                  load;
	logic                  conv_done;
	logic                  emit_fire;
	logic                  emit_last;
	logic [7:0]            char_c;
	logic                  out_valid_q;
	logic [7:0]            char_q;
	logic                  last_q;

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					state_d = (job.op == OP_DEC) ? B_CONV : B_SIZE;
				end
			end
			B_CONV: begin
				if (conv_done) begin
					state_d = B_SIZE;
				end
			end
			B_SIZE: state_d = B_EMIT;
			B_EMIT: begin
				if (emit_fire && emit_last) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// control and datapath selection
	always_comb begin
		job_ready = (state_q == B_IDLE);
		load      = job_ready && job_valid;
		conv_done = (bit_cnt_q == BIT_W'(VALUE_BITS - 1));
		emit_fire = (state_q == B_EMIT) && (!out_valid_q || out_ready);
		emit_last = (pos_q + 1'b1 == len_q);

		for (int i = 0; i < STORE_DEPTH; i++) begin
			adj[i] = (digits_q[i] >= 4'd5) ? digits_q[i] + 4'd3 : digits_q[i];
		end
		conv_c[0] = {adj[0][2:0], shift_q[VALUE_BITS-1]};
		for (int i = 1; i < STORE_DEPTH; i++) begin
			conv_c[i] = {adj[i][2:0], adj[i-1][3]};
		end

		hpad = (STORE_DEPTH*4)'(job.mag);
		for (int i = 0; i < STORE_DEPTH; i++) begin
			hex_c[i] = hpad[4*i +: 4];
		end

		ndig_c = CNT_W'(1);
		for (int i = 1; i < STORE_DEPTH; i++) begin
			if (digits_q[i] != 4'd0) begin
				ndig_c = CNT_W'(i + 1);
			end
		end
		len_c = LEN_W'(ndig_c) + LEN_W'(pre_q);
		if (len_c > LEN_W'(MAX_CHARS)) begin
			len_c = LEN_W'(MAX_CHARS);
		end

		idx_c = ndig_q + LEN_W'(pre_q) - 1'b1 - pos_q;
		if (pos_q < LEN_W'(pre_q)) begin
			if (neg_q) begin
				char_c = CH_MINUS;
			end else begin
				char_c = (pos_q == '0) ? CH_ZERO : CH_LOWER_X;
			end
		end else begin
			char_c = digit_char(digits_q[idx_c[DIG_W-1:0]], op_q == OP_HEX_UP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_q      <= job.op;
			neg_q     <= job.neg;
			shift_q   <= job.mag;
			bit_cnt_q <= '0;
			for (int i = 0; i < STORE_DEPTH; i++) begin
				digits_q[i] <= (job.op == OP_DEC) ? 4'd0 : hex_c[i];
			end
			case (job.op) inside
				OP_DEC:  pre_q <= {1'b0, job.neg};
				OP_PTR:  pre_q <= 2'd2;
				default: pre_q <= 2'd0;
			endcase
		end
		if (state_q == B_CONV) begin
			shift_q   <= shift_q << 1;
			bit_cnt_q <= bit_cnt_q + 1'b1;
			for (int i = 0; i < STORE_DEPTH; i++) begin
				digits_q[i] <= conv_c[i];
			end
		end
		if (state_q == B_SIZE) begin
			ndig_q <= LEN_W'(ndig_c);
			len_q  <= len_c;
			pos_q  <= '0;
		end
		if (emit_fire) begin
			char_q <= char_c;
			last_q <= emit_last;
			pos_q  <= pos_q + 1'b1;
		end
	end

endmodule

>>> hw/rtl/number_to_ascii_formatter_core.sv
// Top level of the number-to-ASCII formatter.
//
//   channel  dir  tdata                         tuser          tlast
//   s_       in   [63:0] value                  [1:0] operation  -
//   m_       out  [7:0] character               -              last character
//
// Decimal: load, the shift-and-adjust steps of the double-dabble loop over all value bits,
// a sizing step, then one character per cycle while the m_ side is not stalled.
// Hex and pointer: load and sizing with no loop, then one character per cycle while m_ is not stalled.
// A front register and a two-entry job queue take further items while one converts;
// each job passes through the front register and then the queue before the load.
// Reset clears all handshake state; a stalled m_ side holds the current character.
module number_to_ascii_formatter_core import n2a_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [63:0] value
	input  logic [1:0]  s_tuser,  // [1:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [7:0] character
	output logic        m_tlast
);

	logic f_valid;
	logic f_ready;
	job_t f_job;
	logic q_valid;
	logic q_ready;
	job_t q_job;

	n2a_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.value     (s_tdata),
		.operation (s_tuser),
		.job_valid (f_valid),
		.job_ready (f_ready),
		.job       (f_job)
	);

	n2a_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_job   (f_job),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_job    (q_job)
	);

	n2a_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job_ready (q_ready),
		.job       (q_job),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.character (m_tdata),
		.last      (m_tlast)
	);

endmodule

>>> hw/rtl/n2a_checker.sv
// Port-level checks of the formatter, bound to the top level.
module n2a_checker import n2a_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	logic first_q;
	logic is_digit;
	logic is_hex_lo;
	logic is_hex_up;

	assign is_digit  = (m_tdata >= CH_ZERO) && (m_tdata <= CH_NINE);
	assign is_hex_lo = (m_tdata >= CH_LOWER_A) && (m_tdata <= CH_LOWER_F);
	assign is_hex_up = (m_tdata >= CH_UPPER_A) && (m_tdata <= CH_UPPER_F);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (m_tvalid && m_tready) begin
			first_q <= m_tlast;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output transfer changed while stalled");

	a_charset: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> is_digit || is_hex_lo || is_hex_up
			|| (m_tdata == CH_MINUS) || (m_tdata == CH_LOWER_X))
		else $error("character outside the formatter's set");

	a_minus_first: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata == CH_MINUS) |-> first_q && !m_tlast)
		else $error("minus sign not leading a number");

	a_x_second: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata == CH_LOWER_X) |-> !first_q && !m_tlast)
		else $error("pointer prefix misplaced");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid)
		else $error("input transfer withdrawn while stalled");

endmodule

bind number_to_ascii_formatter_core n2a_checker u_n2a_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
